// ===== sv/des_pkg.sv =====
// DES package: the published permutation, expansion, key-schedule and S-box tables.
// Also holds the pipeline state type and the bit-level helper functions.
// Used by des_round_cell, des_block_encrypt and tb_top; depends on nothing else.
`default_nettype none
package des_pkg;

  // Bit numbers in the tables count from 1 at the MSB.
  localparam logic [6:0] IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [5:0] E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
    6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  localparam logic [1:0] ROT_TAB [16] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  localparam logic [3:0] SBOX_TAB [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
  };

  // Block halves and key halves that travel down the round chain together.
  typedef struct packed {
    logic [31:0] l;
    logic [31:0] r;
    logic [27:0] c;
    logic [27:0] d;
  } des_state_t;

  function automatic logic [63:0] perm_ip(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) y[6'(63 - i)] = x[6'(7'd64 - IP_TAB[i])];
    return y;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) y[6'(63 - i)] = x[6'(7'd64 - FP_TAB[i])];
    return y;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] x);
    logic [55:0] y;
    for (int i = 0; i < 56; i++) y[6'(55 - i)] = x[6'(7'd64 - PC1_TAB[i])];
    return y;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] x);
    logic [47:0] y;
    for (int i = 0; i < 48; i++) y[6'(47 - i)] = x[6'(6'd56 - PC2_TAB[i])];
    return y;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] x, input logic [1:0] amt);
    logic [27:0] y;
    case (amt)
      2'd1:    y = {x[26:0], x[27]};
      2'd2:    y = {x[25:0], x[27:26]};
      default: y = x;
    endcase
    return y;
  endfunction

  // Round function: expand, mix in the subkey, substitute, permute.
  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] subkey);
    logic [47:0] ex;
    logic [5:0]  six;
    logic [31:0] sout;
    logic [31:0] y;
    for (int i = 0; i < 48; i++) ex[6'(47 - i)] = r[5'(6'd32 - E_TAB[i])];
    ex = ex ^ subkey;
    for (int b = 0; b < 8; b++) begin
      six = ex[47 - 6 * b -: 6];
      sout[31 - 4 * b -: 4] = SBOX_TAB[b][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) y[5'(31 - i)] = sout[5'(6'd32 - P_TAB[i])];
    return y;
  endfunction

endpackage
`default_nettype wire

// ===== sv/des_block_encrypt.sv =====
// DES block encryption, top level: key register, initial permutation and key PC1,
// a chain of ROUND_COUNT round cells, swap and final permutation on the output.
// Depends on des_pkg and des_round_cell.
//
//   channel | direction | width | content
//   in_*    | in        | 64    | plain_block
//   out_*   | out       | 64    | cipher_block
//   cfg_*   | in        | 64    | cipher_key (always ready)
//
// One block enters per cycle unless a stalled output has filled the chain; one round per round cell.
// Each cell registers one round, so the chain length sets the latency.
// A stalled output holds the last cell; empty cells upstream keep filling.
// Synchronous active-low reset clears the key and all valid bits.
`default_nettype none
module des_block_encrypt #(
  parameter int unsigned ROUND_COUNT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] plain_block
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] cipher_block
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] cfg_data    // [63:0] cipher_key
);
  import des_pkg::*;

  logic [63:0] key_r;
  logic [55:0] key56;
  logic [63:0] blk_ip;
  des_state_t  chain_state [ROUND_COUNT + 1];
  logic        chain_valid [ROUND_COUNT + 1];
  logic        chain_ready [ROUND_COUNT + 1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= 64'd0;
    end else if (cfg_valid) begin
      key_r <= cfg_data;
    end
  end

  always_comb begin
    key56 = perm_pc1(key_r);
    blk_ip = perm_ip(in_tdata);
    chain_state[0].l = blk_ip[63:32];
    chain_state[0].r = blk_ip[31:0];
    chain_state[0].c = key56[55:28];
    chain_state[0].d = key56[27:0];
  end

  assign chain_valid[0] = in_tvalid;
  assign in_tready = chain_ready[0];

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    des_round_cell #(
      .ROUND_IDX(g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_valid(chain_valid[g]),
      .up_state(chain_state[g]),
      .up_ready(chain_ready[g]),
      .dn_valid(chain_valid[g + 1]),
      .dn_state(chain_state[g + 1]),
      .dn_ready(chain_ready[g + 1])
    );
  end

  // Swap the halves on the way out.
  assign chain_ready[ROUND_COUNT] = out_tready;
  assign out_tvalid = chain_valid[ROUND_COUNT];
  assign out_tdata = perm_fp({chain_state[ROUND_COUNT].r, chain_state[ROUND_COUNT].l});

endmodule
`default_nettype wire

// ===== sv/des_round_cell.sv =====
// One DES round cell: applies round ROUND_IDX to the upstream state and registers it.
// Holds its own valid bit; stalls only when full and the downstream cell is not ready.
// Depends on des_pkg.
`default_nettype none
module des_round_cell #(
  parameter int unsigned ROUND_IDX = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  input  wire des_pkg::des_state_t up_state,
  output logic                    up_ready,
  output logic                    dn_valid,
  output des_pkg::des_state_t     dn_state,
  input  wire logic               dn_ready
);
  import des_pkg::*;

  logic        valid_r, valid_nxt;
  des_state_t  state_r, state_nxt;
  logic [27:0] c_rot, d_rot;
  logic [47:0] subkey;

  // Take a new request when empty or when the held one moves on this cycle.
  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    c_rot = rot28(up_state.c, ROT_TAB[4'(ROUND_IDX)]);
    d_rot = rot28(up_state.d, ROT_TAB[4'(ROUND_IDX)]);
    subkey = perm_pc2({c_rot, d_rot});
    state_nxt.l = up_state.r;
    state_nxt.r = up_state.l ^ feistel(up_state.r, subkey);
    state_nxt.c = c_rot;
    state_nxt.d = d_rot;
    valid_nxt = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      state_r <= state_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_state = state_r;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for des_block_encrypt: encrypts known DES vectors, then random blocks under
// several keys, and checks each ciphertext against the vector table or a local DES predictor.
// Depends on des_pkg (tables) and the des_block_encrypt RTL.
`timescale 1ns / 1ps
module tb_top;
  import des_pkg::*;

  localparam int unsigned ROUND_COUNT    = 16;
  localparam int unsigned NUM_DIR        = 17;
  localparam int unsigned NUM_PHASES     = 7;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  localparam logic [63:0] WEAK_KEY = 64'h1F1F_1F1F_0E0E_0E0E;

  typedef struct packed {
    logic        load_key;
    logic [63:0] key;
    logic [63:0] plain;
    logic        known;
    logic [63:0] cipher;
  } dir_row_t;

  // Published DES vectors; rows marked unknown go through the predictor.
  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    '{1'b0, 64'h0000000000000000, 64'h0000000000000000, 1'b1, 64'h8CA64DE9C1B123A7},
    '{1'b0, 64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0},
    '{1'b1, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1, 64'h7359B2163E4EDC58},
    '{1'b0, 64'h0000000000000000, 64'h0000000000000000, 1'b0, 64'h0},
    // parity bits alone: same results as the all-zero and all-one keys
    '{1'b1, 64'h0101010101010101, 64'h0000000000000000, 1'b1, 64'h8CA64DE9C1B123A7},
    '{1'b1, 64'hFEFEFEFEFEFEFEFE, 64'hFFFFFFFFFFFFFFFF, 1'b1, 64'h7359B2163E4EDC58},
    '{1'b1, 64'h3000000000000000, 64'h1000000000000001, 1'b1, 64'h958E6E627A05557B},
    '{1'b1, 64'h1111111111111111, 64'h1111111111111111, 1'b1, 64'hF40379AB9E0EC533},
    '{1'b0, 64'h0000000000000000, 64'h0123456789ABCDEF, 1'b1, 64'h8A5AE1F81AB8F2DD},
    '{1'b1, 64'h0123456789ABCDEF, 64'h1111111111111111, 1'b1, 64'h17668DFC7292532D},
    '{1'b1, 64'hFEDCBA9876543210, 64'h0123456789ABCDEF, 1'b1, 64'hED39D950FA74BCC4},
    '{1'b1, 64'h133457799BBCDFF1, 64'h0123456789ABCDEF, 1'b1, 64'h85E813540F0AB405},
    '{1'b1, 64'h0E329232EA6D0D73, 64'h8787878787878787, 1'b1, 64'h0000000000000000},
    '{1'b0, 64'h0000000000000000, 64'h8000000000000000, 1'b0, 64'h0},
    '{1'b0, 64'h0000000000000000, 64'h0000000000000001, 1'b0, 64'h0},
    '{1'b0, 64'h0000000000000000, 64'hAAAAAAAAAAAAAAAA, 1'b0, 64'h0},
    '{1'b0, 64'h0000000000000000, 64'h5555555555555555, 1'b0, 64'h0}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // [63:0] plain_block
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;         // [63:0] cipher_block
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data   = '0;   // [63:0] cipher_key

  logic [63:0] cipher_q [$];
  logic [63:0] key_shadow  = '0;
  int unsigned err_count   = 0;
  int unsigned idle_cycles = 0;
  bit          in_steady   = 1'b0;
  bit          out_steady  = 1'b0;

  always #5 clk = ~clk;

  des_block_encrypt #(.ROUND_COUNT(ROUND_COUNT)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Full DES encryption of one block under a 64-bit key.
  function automatic logic [63:0] des_cipher_of(input logic [63:0] key,
                                                input logic [63:0] plain);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [63:0] blk;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] nr;
    logic [47:0] sub;
    logic [47:0] ex;
    logic [31:0] sb;
    logic [31:0] f;
    logic [5:0]  six;
    logic [63:0] res;
    int unsigned rounds;
    rounds = (ROUND_COUNT > 16) ? 16 : ROUND_COUNT;
    for (int i = 0; i < 56; i++) cd[55 - i] = key[64 - PC1_TAB[i]];
    c = cd[55:28];
    d = cd[27:0];
    for (int i = 0; i < 64; i++) blk[63 - i] = plain[64 - IP_TAB[i]];
    l = blk[63:32];
    r = blk[31:0];
    for (int rnd = 0; rnd < rounds; rnd++) begin
      for (int s = 0; s < ROT_TAB[rnd]; s++) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cd = {c, d};
      for (int i = 0; i < 48; i++) sub[47 - i] = cd[56 - PC2_TAB[i]];
      for (int i = 0; i < 48; i++) ex[47 - i] = r[32 - E_TAB[i]];
      ex = ex ^ sub;
      for (int b = 0; b < 8; b++) begin
        six = ex[47 - 6 * b -: 6];
        // row from the outer bits, column from the middle four
        sb[31 - 4 * b -: 4] = SBOX_TAB[b][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < 32; i++) f[31 - i] = sb[32 - P_TAB[i]];
      nr = l ^ f;
      l  = r;
      r  = nr;
    end
    blk = {r, l};
    for (int i = 0; i < 64; i++) res[63 - i] = blk[64 - FP_TAB[i]];
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand_block();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return {$urandom, $urandom};
    if (sel < 80) return 64'd1 << $urandom_range(0, 63);
    if (sel < 90) return ~(64'd1 << $urandom_range(0, 63));
    if (sel < 95) return '0;
    return '1;
  endfunction

  function automatic logic [63:0] phase_key(input int unsigned ph);
    case (ph)
      1:       return '1;
      3:       return '0;
      4:       return WEAK_KEY;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (err_count < 100)
      $display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Send one plaintext request and queue its ciphertext once accepted.
  task automatic push_block(input logic [63:0] blk, input logic known,
                            input logic [63:0] typed);
    int unsigned gap;
    gap = in_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= blk;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    cipher_q.push_back(known ? typed : des_cipher_of(key_shadow, blk));
  endtask

  // Drain the pipeline, then write the key register.
  task automatic load_key(input logic [63:0] k);
    in_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    key_shadow = k;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < NUM_DIR; i++) begin
      if (DIR_TAB[i].load_key) load_key(DIR_TAB[i].key);
      push_block(DIR_TAB[i].plain, DIR_TAB[i].known, DIR_TAB[i].cipher);
    end
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      load_key(phase_key(ph));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) in_steady = ($urandom_range(0, 3) == 0);
        push_block(rand_block(), 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    // hold a little longer so that stray results show up
    repeat (ROUND_COUNT + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Output backpressure: random stalls with occasional stall-free stretches.
  initial begin
    int unsigned stall;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      if ($urandom_range(0, 19) == 0) out_steady = ~out_steady;
      stall = out_steady ? 0 : pick_gap();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_q.size() == 0) begin
        flag_mismatch("unexpected cipher_block", out_tdata, 'x);
      end else begin
        if (out_tdata !== cipher_q[0]) flag_mismatch("cipher_block", out_tdata, cipher_q[0]);
        void'(cipher_q.pop_front());
      end
    end
  end

  // Stop a hung run: count cycles with no request moving on any channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
